/* rtl/keypad_matrix_scanner_assert.svh */
// assertion macros for the keypad matrix scanner
// all checks are sampled on i_clk and held off while i_rst_n is low
`ifndef KEYPAD_MATRIX_SCANNER_ASSERT_SVH
`define KEYPAD_MATRIX_SCANNER_ASSERT_SVH

// same-cycle implication
`define KMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/kms_pkg.sv */
package kms_pkg;

    // field widths of the stream items
    localparam int FUNC_W       = 2;
    localparam int ROW_LEVELS_W = 4;
    localparam int COL_DRIVE_W  = 4;
    localparam int KEY_POS_W    = 2;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 16;

    // internal counters
    localparam int            PRESS_W   = 5;
    localparam logic [4:0]    PRESS_MAX = 5'd31;
    localparam int            HOLD_W    = 16;

    // configuration port
    localparam int              APB_DATA_W     = 32;
    localparam int              APB_ADDR_W     = 3;
    localparam logic [15:0]     HOLD_TICKS_RST = 16'd100;
    localparam logic [0:0]      REG_HOLD_TICKS = 1'b0;

    // default matrix size
    localparam int NUM_ROWS_DEF = 4;
    localparam int NUM_COLS_DEF = 4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_START  = 2'd2
    } t_func;

    typedef struct packed {
        logic [KEY_POS_W-1:0]   key_col;
        logic [KEY_POS_W-1:0]   key_row;
        logic                   multiple_keys;
        logic                   key_valid;
        logic                   scan_done;
        logic                   held;
        logic                   any_pressed;
        logic [COL_DRIVE_W-1:0] col_drive;
    } t_result;

endpackage

/* rtl/keypad_matrix_scanner.sv */
// Keypad matrix scanner. Each input transfer is one pin sample, one hold-timer tick or a
// scan restart, selected by s_tuser. Two scan samples visit each matrix position in row-major
// order: the first records the row level and drives the column, the second checks for a
// level change and releases it. The transfer that finishes the last position carries
// m_tlast with the key report. The block takes one transfer per clock cycle while s_tready
// is high and registers its result; each transfer updates the scan and hold registers.
// A two-deep output stage (result register plus skid) lets input keep flowing while a result
// waits, so s_tready drops only when both slots are full.
// hold_ticks sits at address 0 of the configuration port and resets to 100.
`include "keypad_matrix_scanner_assert.svh"

module keypad_matrix_scanner #(
    parameter int NUM_ROWS = kms_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLS = kms_pkg::NUM_COLS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kms_pkg::IN_TDATA_W-1:0]  s_tdata,   // [3:0] row_levels, [7:4] zero
    input  logic [kms_pkg::FUNC_W-1:0]      s_tuser,   // [1:0] func
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] col_drive, [4] any_pressed, [5] held, [6] key_valid, [7] multiple_keys,
    // [9:8] key_row, [11:10] key_col, [15:12] zero
    output logic [kms_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,   // scan_done
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [kms_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [kms_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [kms_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import kms_pkg::*;

    localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int COL_W = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam int LVL_W = 1 << ROW_W;

    // scan and hold state
    logic [ROW_W-1:0]   r_scan_row,     n_scan_row;
    logic [COL_W-1:0]   r_scan_col,     n_scan_col;
    logic               r_drive_phase,  n_drive_phase;
    logic               r_baseline,     n_baseline;
    logic [PRESS_W-1:0] r_press_count,  n_press_count;
    logic [ROW_W-1:0]   r_found_row,    n_found_row;
    logic [COL_W-1:0]   r_found_col,    n_found_col;
    logic [HOLD_W-1:0]  r_hold_count,   n_hold_count;
    logic [HOLD_W-1:0]  r_hold_ticks;

    // output stage
    t_result            r_out,  n_out;
    t_result            r_skid, n_skid;
    logic               r_out_valid,  n_out_valid;
    logic               r_skid_valid, n_skid_valid;

    t_func              func;
    logic [LVL_W-1:0]   levels;
    logic               pressed;
    logic               level;
    logic               in_xfer;
    logic               out_xfer;
    logic               cfg_wr;
    logic [0:0]         reg_index;
    t_result            res;

    assign func      = t_func'(s_tuser);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_xfer  = r_out_valid && m_tready;
    assign s_tready  = !r_skid_valid;

    // apb: always ready, index is the word address
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign prdata    = (reg_index == REG_HOLD_TICKS) ?
                       {{(APB_DATA_W-HOLD_W){1'b0}}, r_hold_ticks} : '0;

    // row levels widened to the scan index range, rows past the pins read low
    for (genvar i = 0; i < LVL_W; i++) begin : g_lvl
        if (i < ROW_LEVELS_W) begin : g_pin
            assign levels[i] = s_tdata[i];
        end else begin : g_none
            assign levels[i] = 1'b0;
        end
    end

    assign pressed = |(~levels[NUM_ROWS-1:0]);
    assign level   = levels[r_scan_row];

    always_comb begin
        n_scan_row    = r_scan_row;
        n_scan_col    = r_scan_col;
        n_drive_phase = r_drive_phase;
        n_baseline    = r_baseline;
        n_press_count = r_press_count;
        n_found_row   = r_found_row;
        n_found_col   = r_found_col;
        n_hold_count  = r_hold_count;
        res           = '0;

        case (func)
            FUNC_TICK: begin
                if (pressed) begin
                    if (r_hold_count < r_hold_ticks) begin
                        n_hold_count = r_hold_count + 1'b1;
                    end
                end else begin
                    n_hold_count = '0;
                end
            end
            FUNC_SAMPLE: begin
                if (!r_drive_phase) begin
                    n_baseline    = level;
                    n_drive_phase = 1'b1;
                end else begin
                    n_drive_phase = 1'b0;
                    if (level != r_baseline) begin
                        n_found_row = r_scan_row;
                        n_found_col = r_scan_col;
                        if (r_press_count < PRESS_MAX) begin
                            n_press_count = r_press_count + 1'b1;
                        end
                    end
                    if (r_scan_col != COL_W'(NUM_COLS - 1)) begin
                        n_scan_col = r_scan_col + 1'b1;
                    end else if (r_scan_row != ROW_W'(NUM_ROWS - 1)) begin
                        n_scan_col = '0;
                        n_scan_row = r_scan_row + 1'b1;
                    end else begin
                        // last position: report and start over
                        res.scan_done     = 1'b1;
                        res.key_valid     = (n_press_count != '0);
                        res.multiple_keys = (n_press_count > PRESS_W'(1));
                        res.key_row       = KEY_POS_W'(n_found_row);
                        res.key_col       = KEY_POS_W'(n_found_col);
                        n_scan_row        = '0;
                        n_scan_col        = '0;
                        n_baseline        = 1'b0;
                        n_press_count     = '0;
                        n_found_row       = '0;
                        n_found_col       = '0;
                    end
                end
            end
            FUNC_START: begin
                n_scan_row    = '0;
                n_scan_col    = '0;
                n_drive_phase = 1'b0;
                n_baseline    = 1'b0;
                n_press_count = '0;
                n_found_row   = '0;
                n_found_col   = '0;
            end
            default: begin
                // unused code leaves the state alone
            end
        endcase

        for (int c = 0; c < COL_DRIVE_W; c++) begin
            res.col_drive[c] = n_drive_phase && (c < NUM_COLS) && (n_scan_col == COL_W'(c));
        end
        res.any_pressed = pressed;
        res.held        = (n_hold_count >= r_hold_ticks);
    end

    // output register with skid slot behind it
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_xfer) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else if (in_xfer) begin
                n_out        = res;
            end else begin
                n_out_valid  = 1'b0;
            end
        end else if (in_xfer) begin
            if (!r_out_valid) begin
                n_out        = res;
                n_out_valid  = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row    <= '0;
            r_scan_col    <= '0;
            r_drive_phase <= 1'b0;
            r_baseline    <= 1'b0;
            r_press_count <= '0;
            r_found_row   <= '0;
            r_found_col   <= '0;
            r_hold_count  <= '0;
        end else if (in_xfer) begin
            r_scan_row    <= n_scan_row;
            r_scan_col    <= n_scan_col;
            r_drive_phase <= n_drive_phase;
            r_baseline    <= n_baseline;
            r_press_count <= n_press_count;
            r_found_row   <= n_found_row;
            r_found_col   <= n_found_col;
            r_hold_count  <= n_hold_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= HOLD_TICKS_RST;
        end else if (cfg_wr && (reg_index == REG_HOLD_TICKS)) begin
            r_hold_ticks <= pwdata[HOLD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign m_tvalid = r_out_valid;
    assign m_tlast  = r_out.scan_done;
    assign m_tdata  = {{(OUT_TDATA_W-12){1'b0}}, r_out.key_col, r_out.key_row,
                       r_out.multiple_keys, r_out.key_valid, r_out.held,
                       r_out.any_pressed, r_out.col_drive};

    // a filled skid slot always has a result in front of it
    `KMS_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    // key report fields stay clear outside scan end
    `KMS_ASSERT_NOW(a_report_only_at_end, r_out_valid && !r_out.scan_done,
        !r_out.key_valid && !r_out.multiple_keys && r_out.key_row == '0 && r_out.key_col == '0,
        "key report outside scan end")
    // several keys imply a key and at most one column driven
    `KMS_ASSERT_NOW(a_result_consistent, r_out_valid,
        (!r_out.multiple_keys || r_out.key_valid) && $onehot0(r_out.col_drive),
        "inconsistent result")
    // an accepted start puts the scan back at its origin
    `KMS_ASSERT_NEXT(a_start_clears, in_xfer && func == FUNC_START,
        r_scan_row == '0 && r_scan_col == '0 && !r_drive_phase && r_press_count == '0,
        "start did not clear the scan")

endmodule
